>>> rtl/slc_pkg.sv
// Shared types, constants and helpers for the staircase light controller.
`timescale 1ns / 1ps
package slc_pkg;

	localparam int unsigned DELAY_W = 31;
	localparam int unsigned MIN_W = 11;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned CMD_W = 3;
	localparam int unsigned REG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 31;

	localparam logic [TIME_W-1:0] DEBOUNCE_MS = 32'd50;
	localparam logic [TIME_W-1:0] RETRIGGER_GUARD_MS = 32'd2000;
	localparam logic [MIN_W-1:0] MIN_PER_DAY = 11'd1440;

	localparam logic [CMD_W-1:0] CMD_TICK = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOTE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POLL = 3'd2;
	localparam logic [CMD_W-1:0] CMD_SHORT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_LONG = 3'd4;
	localparam logic [CMD_W-1:0] CMD_FORCE_OFF = 3'd5;

	localparam logic [REG_IDX_W-1:0] REG_OFF_DELAY = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_OVERRIDE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_TIMEOUT = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WIN_EN = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WIN_START = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WIN_END = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_INVERT = 3'd6;

	localparam logic [DELAY_W-1:0] OFF_DELAY_RST = 31'd60000;
	localparam logic [DELAY_W-1:0] OVERRIDE_RST = 31'd300000;

	typedef struct packed {
		logic [DELAY_W-1:0] off_delay_ms;
		logic [DELAY_W-1:0] button_override_ms;
		logic [DELAY_W-1:0] motion_timeout_ms;
		logic window_enabled;
		logic [MIN_W-1:0] window_start_min;
		logic [MIN_W-1:0] window_end_min;
		logic local_motion_invert;
	} slc_cfg_t;

	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		logic local_motion_raw;
		logic remote_source;
		logic remote_active;
		logic [MIN_W-1:0] minute_of_day;
		logic clock_valid;
	} slc_req_t;

	typedef struct packed {
		logic [TIME_W-1:0] time_ms;
		logic raw_level;
		logic stable_level;
		logic [TIME_W-1:0] edge_time;
		logic [2:0] motion_flags;
		logic [2:0][TIME_W-1:0] last_event_time;
		logic relay_state;
		logic force_latch;
		logic ov_v;
		logic [TIME_W-1:0] ov_t;
		logic sup_v;
		logic [TIME_W-1:0] sup_t;
		logic off_v;
		logic [TIME_W-1:0] off_t;
		logic rearm_v;
		logic [TIME_W-1:0] rearm_t;
	} slc_state_t;

	typedef struct packed {
		logic relay_on;
		logic relay_command;
		logic all_channels;
		logic motion_led;
		logic [1:0] motion_count;
		logic latched_on;
		logic override_active;
	} slc_res_t;

	function automatic logic before_f(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
		logic [TIME_W-1:0] d;
		d = a - b;
		return d[TIME_W-1];
	endfunction

endpackage

>>> rtl/slc_step.sv
// Next-state and result logic for one controller request.
`timescale 1ns / 1ps
module slc_step (
	input  slc_pkg::slc_state_t state,
	input  slc_pkg::slc_cfg_t   cfg,
	input  slc_pkg::slc_req_t   req,
	output slc_pkg::slc_state_t state_nx,
	output slc_pkg::slc_res_t   res
);

	typedef struct packed {
		slc_pkg::slc_state_t st;
		logic drove;
	} slc_eval_t;

	function automatic logic [slc_pkg::MIN_W-1:0] mod_day(input logic [slc_pkg::MIN_W-1:0] x);
		return (x >= slc_pkg::MIN_PER_DAY) ? x - slc_pkg::MIN_PER_DAY : x;
	endfunction

	function automatic slc_eval_t eval_f(
		input slc_pkg::slc_state_t s,
		input logic [slc_pkg::DELAY_W-1:0] off_delay,
		input logic win
	);
		logic motion;
		logic ov_live;
		logic sup_live;
		logic rearm_live;
		logic desired;
		slc_eval_t r;
		r.st = s;
		r.drove = 1'b0;
		motion = |s.motion_flags;
		ov_live = s.ov_v && slc_pkg::before_f(s.time_ms, s.ov_t);
		sup_live = s.sup_v && slc_pkg::before_f(s.time_ms, s.sup_t);
		rearm_live = s.rearm_v && slc_pkg::before_f(s.time_ms, s.rearm_t);
		desired = s.force_latch || ov_live || (!sup_live && !rearm_live && win && motion);
		if (desired) begin
			r.st.off_v = 1'b0;
			if (!s.relay_state) begin
				r.st.relay_state = 1'b1;
				r.drove = 1'b1;
			end
		end else if (motion || !s.relay_state) begin
			r.st.off_v = 1'b0;
		end else if (!s.off_v) begin
			r.st.off_v = 1'b1;
			r.st.off_t = s.time_ms + {1'b0, off_delay};
		end else if (!slc_pkg::before_f(s.time_ms, s.off_t)) begin
			r.st.relay_state = 1'b0;
			r.drove = 1'b1;
			r.st.rearm_v = 1'b1;
			r.st.rearm_t = s.time_ms + slc_pkg::RETRIGGER_GUARD_MS;
			r.st.off_v = 1'b0;
		end
		return r;
	endfunction

	logic [slc_pkg::MIN_W-1:0] win_s;
	logic [slc_pkg::MIN_W-1:0] win_e;
	logic [slc_pkg::MIN_W-1:0] win_m;
	logic win_open;

	always_comb begin
		win_s = mod_day(cfg.window_start_min);
		win_e = mod_day(cfg.window_end_min);
		win_m = mod_day(req.minute_of_day);
		if (!cfg.window_enabled || !req.clock_valid || win_s == win_e) begin
			win_open = 1'b1;
		end else if (win_s < win_e) begin
			win_open = (win_m >= win_s) && (win_m < win_e);
		end else begin
			win_open = (win_m >= win_s) || (win_m < win_e);
		end
	end

	slc_pkg::slc_state_t nx;
	slc_eval_t ev;
	logic [slc_pkg::TIME_W-1:0] now;
	logic [1:0] ridx;
	logic lvl;
	logic drove;
	logic drove_all;

	always_comb begin
		nx = state;
		ev = '0;
		drove = 1'b0;
		drove_all = 1'b0;
		lvl = req.local_motion_raw ^ cfg.local_motion_invert;
		ridx = 2'd1 + {1'b0, req.remote_source};
		now = (req.cmd == slc_pkg::CMD_TICK) ? state.time_ms + 32'd1 : state.time_ms;
		nx.time_ms = now;
		if (nx.ov_v && !slc_pkg::before_f(now, nx.ov_t)) nx.ov_v = 1'b0;
		if (nx.sup_v && !slc_pkg::before_f(now, nx.sup_t)) nx.sup_v = 1'b0;
		if (nx.rearm_v && !slc_pkg::before_f(now, nx.rearm_t)) nx.rearm_v = 1'b0;

		case (req.cmd) inside
			slc_pkg::CMD_TICK: begin
				if (lvl != nx.raw_level) begin
					nx.raw_level = lvl;
					nx.edge_time = now;
				end
				if (nx.stable_level != nx.raw_level &&
				    !slc_pkg::before_f(now, nx.edge_time + slc_pkg::DEBOUNCE_MS)) begin
					nx.stable_level = nx.raw_level;
					nx.motion_flags[0] = nx.raw_level;
					nx.last_event_time[0] = now;
					ev = eval_f(nx, cfg.off_delay_ms, win_open);
					nx = ev.st;
					drove = ev.drove;
				end
				for (int i = 0; i < 3; i++) begin
					if (cfg.motion_timeout_ms != '0 && nx.motion_flags[i] &&
					    (now - nx.last_event_time[i]) > {1'b0, cfg.motion_timeout_ms}) begin
						nx.motion_flags[i] = 1'b0;
					end
				end
				ev = eval_f(nx, cfg.off_delay_ms, win_open);
				nx = ev.st;
				drove = drove | ev.drove;
			end
			slc_pkg::CMD_REMOTE, slc_pkg::CMD_POLL: begin
				if (req.cmd == slc_pkg::CMD_REMOTE ||
				    req.remote_active != nx.motion_flags[ridx]) begin
					nx.motion_flags[ridx] = req.remote_active;
					nx.last_event_time[ridx] = now;
					ev = eval_f(nx, cfg.off_delay_ms, win_open);
					nx = ev.st;
					drove = ev.drove;
				end else if (req.remote_active) begin
					nx.last_event_time[ridx] = now;
				end
			end
			slc_pkg::CMD_SHORT: begin
				nx.force_latch = 1'b0;
				nx.off_v = 1'b0;
				drove = 1'b1;
				if (state.relay_state) begin
					nx.ov_v = 1'b0;
					nx.sup_v = 1'b1;
					nx.sup_t = now + {1'b0, cfg.button_override_ms};
					nx.relay_state = 1'b0;
					drove_all = 1'b1;
				end else begin
					nx.sup_v = 1'b0;
					nx.ov_v = 1'b1;
					nx.ov_t = now + {1'b0, cfg.button_override_ms};
					nx.relay_state = 1'b1;
				end
			end
			slc_pkg::CMD_LONG: begin
				nx.force_latch = 1'b1;
				nx.ov_v = 1'b0;
				nx.sup_v = 1'b0;
				nx.off_v = 1'b0;
				nx.relay_state = 1'b1;
				drove = 1'b1;
				drove_all = 1'b1;
			end
			slc_pkg::CMD_FORCE_OFF: begin
				nx.force_latch = 1'b0;
				nx.ov_v = 1'b0;
				nx.off_v = 1'b0;
				nx.sup_v = 1'b1;
				nx.sup_t = now + {1'b0, cfg.button_override_ms};
				nx.relay_state = 1'b0;
				drove = 1'b1;
				drove_all = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign state_nx = nx;
	assign res.relay_on = nx.relay_state;
	assign res.relay_command = drove;
	assign res.all_channels = drove & drove_all;
	assign res.motion_led = nx.motion_flags[0];
	assign res.motion_count = {1'b0, nx.motion_flags[0]} + {1'b0, nx.motion_flags[1]} +
		{1'b0, nx.motion_flags[2]};
	assign res.latched_on = nx.force_latch;
	assign res.override_active = nx.ov_v && slc_pkg::before_f(now, nx.ov_t);

endmodule

>>> rtl/staircase_light_controller.sv
// Top level of the staircase light controller: request register, state and result register.
//
//   channel  direction  handshake             payload
//   in       to block   in_valid / in_stall   cmd, local_motion_raw, remote_source,
//                                             remote_active, minute_of_day, clock_valid
//   out      from block out_valid / out_stall relay_on, relay_command, all_channels,
//                                             motion_led, motion_count, latched_on,
//                                             override_active
//   cfg      to block   cfg_wr_en             cfg_index, cfg_data
//
// A request waits in the request register after acceptance; the step logic runs from it
// straight into the result register. One request is accepted per cycle while not stalled.
// Reset clears all controller state (lights off, no deadlines) and loads register defaults.
// A stalled result holds; the request register fills behind it and then stalls the input.
`timescale 1ns / 1ps
module staircase_light_controller (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [slc_pkg::CMD_W-1:0]       cmd,
	input  logic                            local_motion_raw,
	input  logic                            remote_source,
	input  logic                            remote_active,
	input  logic [slc_pkg::MIN_W-1:0]       minute_of_day,
	input  logic                            clock_valid,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            relay_on,
	output logic                            relay_command,
	output logic                            all_channels,
	output logic                            motion_led,
	output logic [1:0]                      motion_count,
	output logic                            latched_on,
	output logic                            override_active,
	input  logic                            cfg_wr_en,
	input  logic [slc_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [slc_pkg::CFG_DATA_W-1:0]  cfg_data
);

	slc_pkg::slc_cfg_t cfg_q;
	slc_pkg::slc_req_t req_s1;
	logic valid_s1;
	slc_pkg::slc_state_t state_q;
	slc_pkg::slc_state_t state_nx;
	slc_pkg::slc_res_t res_nx;
	slc_pkg::slc_res_t res_q;
	logic out_valid_q;
	logic advance;
	logic accept;

	assign advance = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.off_delay_ms <= slc_pkg::OFF_DELAY_RST;
			cfg_q.button_override_ms <= slc_pkg::OVERRIDE_RST;
			cfg_q.motion_timeout_ms <= '0;
			cfg_q.window_enabled <= 1'b0;
			cfg_q.window_start_min <= '0;
			cfg_q.window_end_min <= '0;
			cfg_q.local_motion_invert <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				slc_pkg::REG_OFF_DELAY: cfg_q.off_delay_ms <= cfg_data;
				slc_pkg::REG_OVERRIDE:  cfg_q.button_override_ms <= cfg_data;
				slc_pkg::REG_TIMEOUT:   cfg_q.motion_timeout_ms <= cfg_data;
				slc_pkg::REG_WIN_EN:    cfg_q.window_enabled <= cfg_data[0];
				slc_pkg::REG_WIN_START: cfg_q.window_start_min <= cfg_data[slc_pkg::MIN_W-1:0];
				slc_pkg::REG_WIN_END:   cfg_q.window_end_min <= cfg_data[slc_pkg::MIN_W-1:0];
				slc_pkg::REG_INVERT:    cfg_q.local_motion_invert <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.cmd <= cmd;
			req_s1.local_motion_raw <= local_motion_raw;
			req_s1.remote_source <= remote_source;
			req_s1.remote_active <= remote_active;
			req_s1.minute_of_day <= minute_of_day;
			req_s1.clock_valid <= clock_valid;
		end
	end

	slc_step u_step (
		.state    (state_q),
		.cfg      (cfg_q),
		.req      (req_s1),
		.state_nx (state_nx),
		.res      (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				state_q <= state_nx;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign relay_on = res_q.relay_on;
	assign relay_command = res_q.relay_command;
	assign all_channels = res_q.all_channels;
	assign motion_led = res_q.motion_led;
	assign motion_count = res_q.motion_count;
	assign latched_on = res_q.latched_on;
	assign override_active = res_q.override_active;

`ifndef SYNTH
	a_latch_keeps_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!latched_on || relay_on))
		else $error("latched result with relay off");
	a_override_keeps_on: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!override_active || relay_on))
		else $error("override running with relay off");
	a_all_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!all_channels || relay_command))
		else $error("all channels without relay command");
	a_off_delay_relay_on: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.off_v |-> (state_q.relay_state && state_q.motion_flags == 3'b000))
		else $error("off delay armed while relay off or motion present");
	a_stall_needs_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

>>> tb/tb.sv
// Self-checking testbench for the staircase light controller, with an internal light-state predictor.
`timescale 1ns / 1ps
module tb;

	typedef struct packed {
		logic v;
		logic [slc_pkg::TIME_W-1:0] t;
	} deadline_t;

	localparam deadline_t NO_DEADLINE = '0;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [slc_pkg::CMD_W-1:0] cmd = slc_pkg::CMD_TICK;
	logic local_motion_raw = 1'b0;
	logic remote_source = 1'b0;
	logic remote_active = 1'b0;
	logic [slc_pkg::MIN_W-1:0] minute_of_day = '0;
	logic clock_valid = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic relay_on;
	logic relay_command;
	logic all_channels;
	logic motion_led;
	logic [1:0] motion_count;
	logic latched_on;
	logic override_active;
	logic cfg_wr_en = 1'b0;
	logic [slc_pkg::REG_IDX_W-1:0] cfg_index = '0;
	logic [slc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	staircase_light_controller dut (.*);

	// predicted controller state and register shadow
	logic [slc_pkg::DELAY_W-1:0] cfg_off_delay, cfg_override, cfg_timeout;
	logic cfg_win_en, cfg_invert;
	logic [slc_pkg::MIN_W-1:0] cfg_win_start, cfg_win_end;
	logic [slc_pkg::TIME_W-1:0] now_ms, edge_ms;
	logic raw_q, stable_q, relay_q, latch_q;
	logic [2:0] flags;
	logic [slc_pkg::TIME_W-1:0] last_seen [3];
	deadline_t ovr_dl, sup_dl, offd_dl, rearm_dl;
	logic [slc_pkg::MIN_W-1:0] cur_minute;
	logic cur_clock_ok, drove, drove_all;

	slc_pkg::slc_res_t expected_lights [$];
	bit gaps_on = 1'b1;
	int unsigned stall_left = 0;
	int unsigned errors = 0;
	int unsigned requests_sent = 0;
	int unsigned results_seen = 0;
	int unsigned settings_used = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("tb NOT OK");
		$finish;
	end

	function automatic logic is_before(input logic [slc_pkg::TIME_W-1:0] a,
			input logic [slc_pkg::TIME_W-1:0] b);
		logic [slc_pkg::TIME_W-1:0] d;
		d = a - b;
		return d[slc_pkg::TIME_W-1];
	endfunction

	function automatic logic live(input deadline_t d);
		return d.v && is_before(now_ms, d.t);
	endfunction

	function automatic deadline_t lapse(input deadline_t d);
		if (d.v && !is_before(now_ms, d.t)) return NO_DEADLINE;
		return d;
	endfunction

	function automatic deadline_t arm(input logic [slc_pkg::TIME_W-1:0] delta);
		deadline_t d;
		d.v = 1'b1;
		d.t = now_ms + delta;
		return d;
	endfunction

	function automatic logic in_window();
		logic [slc_pkg::MIN_W-1:0] s, e, m;
		if (!cfg_win_en || !cur_clock_ok) return 1'b1;
		s = cfg_win_start % slc_pkg::MIN_PER_DAY;
		e = cfg_win_end % slc_pkg::MIN_PER_DAY;
		m = cur_minute % slc_pkg::MIN_PER_DAY;
		if (s == e) return 1'b1;
		if (s < e) return m >= s && m < e;
		return m >= s || m < e;
	endfunction

	function automatic logic want_light();
		if (latch_q) return 1'b1;
		if (live(ovr_dl)) return 1'b1;
		if (live(sup_dl)) return 1'b0;
		if (flags != 3'b000 && live(rearm_dl)) return 1'b0;
		if (!in_window()) return 1'b0;
		return flags != 3'b000;
	endfunction

	function automatic void drive_relay(input logic on, input logic all);
		relay_q = on;
		drove = 1'b1;
		drove_all = all;
	endfunction

	function automatic void switch_relay(input logic on);
		if (relay_q != on) drive_relay(on, 1'b0);
	endfunction

	function automatic void settle_lighting();
		if (want_light()) begin
			offd_dl = NO_DEADLINE;
			switch_relay(1'b1);
		end else if (flags != 3'b000 || !relay_q) begin
			offd_dl = NO_DEADLINE;
		end else if (!offd_dl.v) begin
			offd_dl = arm({1'b0, cfg_off_delay});
		end else if (!is_before(now_ms, offd_dl.t)) begin
			switch_relay(1'b0);
			rearm_dl = arm(slc_pkg::RETRIGGER_GUARD_MS);
			offd_dl = NO_DEADLINE;
		end
	endfunction

	function automatic void note_motion(input int idx, input logic act);
		flags[idx] = act;
		last_seen[idx] = now_ms;
		settle_lighting();
	endfunction

	function automatic void drop_stale_flags();
		logic [slc_pkg::TIME_W-1:0] quiet;
		int i;
		if (cfg_timeout == '0) return;
		for (i = 0; i < 3; i++) begin
			quiet = now_ms - last_seen[i];
			if (flags[i] && quiet > {1'b0, cfg_timeout}) flags[i] = 1'b0;
		end
	endfunction

	function automatic slc_pkg::slc_res_t predict_light_step(input slc_pkg::slc_req_t r);
		slc_pkg::slc_res_t res;
		logic lvl;
		int src;
		cur_minute = r.minute_of_day;
		cur_clock_ok = r.clock_valid;
		drove = 1'b0;
		drove_all = 1'b0;
		src = 1 + int'(r.remote_source);
		if (r.cmd == slc_pkg::CMD_TICK) now_ms = now_ms + 1;
		ovr_dl = lapse(ovr_dl);
		sup_dl = lapse(sup_dl);
		rearm_dl = lapse(rearm_dl);
		case (r.cmd)
			slc_pkg::CMD_TICK: begin
				lvl = r.local_motion_raw ^ cfg_invert;
				if (lvl != raw_q) begin
					raw_q = lvl;
					edge_ms = now_ms;
				end
				if (stable_q != raw_q &&
				    !is_before(now_ms, edge_ms + slc_pkg::DEBOUNCE_MS)) begin
					stable_q = raw_q;
					note_motion(0, stable_q);
				end
				drop_stale_flags();
				settle_lighting();
			end
			slc_pkg::CMD_REMOTE: note_motion(src, r.remote_active);
			slc_pkg::CMD_POLL: begin
				if (r.remote_active != flags[src]) note_motion(src, r.remote_active);
				else if (r.remote_active) last_seen[src] = now_ms;
			end
			slc_pkg::CMD_SHORT: begin
				latch_q = 1'b0;
				offd_dl = NO_DEADLINE;
				if (relay_q) begin
					ovr_dl = NO_DEADLINE;
					sup_dl = arm({1'b0, cfg_override});
					drive_relay(1'b0, 1'b1);
				end else begin
					sup_dl = NO_DEADLINE;
					ovr_dl = arm({1'b0, cfg_override});
					switch_relay(1'b1);
				end
			end
			slc_pkg::CMD_LONG: begin
				latch_q = 1'b1;
				ovr_dl = NO_DEADLINE;
				sup_dl = NO_DEADLINE;
				offd_dl = NO_DEADLINE;
				drive_relay(1'b1, 1'b1);
			end
			slc_pkg::CMD_FORCE_OFF: begin
				latch_q = 1'b0;
				ovr_dl = NO_DEADLINE;
				offd_dl = NO_DEADLINE;
				sup_dl = arm({1'b0, cfg_override});
				drive_relay(1'b0, 1'b1);
			end
			default: ;
		endcase
		res.relay_on = relay_q;
		res.relay_command = drove;
		res.all_channels = drove && drove_all;
		res.motion_led = flags[0];
		res.motion_count = 2'($countones(flags));
		res.latched_on = latch_q;
		res.override_active = live(ovr_dl);
		return res;
	endfunction

	task automatic reset_model();
		int i;
		cfg_off_delay = slc_pkg::OFF_DELAY_RST;
		cfg_override = slc_pkg::OVERRIDE_RST;
		cfg_timeout = '0;
		cfg_win_en = 1'b0;
		cfg_win_start = '0;
		cfg_win_end = '0;
		cfg_invert = 1'b0;
		now_ms = '0;
		edge_ms = '0;
		raw_q = 1'b0;
		stable_q = 1'b0;
		relay_q = 1'b0;
		latch_q = 1'b0;
		flags = '0;
		for (i = 0; i < 3; i++) last_seen[i] = '0;
		ovr_dl = NO_DEADLINE;
		sup_dl = NO_DEADLINE;
		offd_dl = NO_DEADLINE;
		rearm_dl = NO_DEADLINE;
	endtask

	task automatic report_mismatch(input string msg);
		if (errors < 40) $display("MISMATCH at %0t: %s", $time, msg);
		errors++;
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s got %0d want %0d",
				results_seen, name, got, want));
	endtask

	// check results and stall the result side in bursts
	always @(posedge clk) begin
		slc_pkg::slc_res_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_lights.size() == 0) begin
				report_mismatch("result with no request pending");
			end else begin
				want = expected_lights.pop_front();
				check_field("relay_on", relay_on, want.relay_on);
				check_field("relay_command", relay_command, want.relay_command);
				check_field("all_channels", all_channels, want.all_channels);
				check_field("motion_led", motion_led, want.motion_led);
				check_field("motion_count", motion_count, want.motion_count);
				check_field("latched_on", latched_on, want.latched_on);
				check_field("override_active", override_active, want.override_active);
			end
			results_seen++;
		end
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (gaps_on && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 15);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic slc_pkg::slc_req_t make_req(input logic [slc_pkg::CMD_W-1:0] c,
			input logic lraw, input logic src, input logic act,
			input logic [slc_pkg::MIN_W-1:0] minute, input logic cv);
		slc_pkg::slc_req_t r;
		r.cmd = c;
		r.local_motion_raw = lraw;
		r.remote_source = src;
		r.remote_active = act;
		r.minute_of_day = minute;
		r.clock_valid = cv;
		return r;
	endfunction

	task automatic send_request(input slc_pkg::slc_req_t r);
		if (gaps_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= r.cmd;
		local_motion_raw <= r.local_motion_raw;
		remote_source <= r.remote_source;
		remote_active <= r.remote_active;
		minute_of_day <= r.minute_of_day;
		clock_valid <= r.clock_valid;
		do @(posedge clk); while (in_stall);
		expected_lights.push_back(predict_light_step(r));
		requests_sent++;
	endtask

	task automatic quiesce();
		in_valid <= 1'b0;
		while (expected_lights.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_reg(input logic [slc_pkg::REG_IDX_W-1:0] idx,
			input logic [slc_pkg::CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
			slc_pkg::REG_OFF_DELAY: cfg_off_delay = value;
			slc_pkg::REG_OVERRIDE: cfg_override = value;
			slc_pkg::REG_TIMEOUT: cfg_timeout = value;
			slc_pkg::REG_WIN_EN: cfg_win_en = value[0];
			slc_pkg::REG_WIN_START: cfg_win_start = value[slc_pkg::MIN_W-1:0];
			slc_pkg::REG_WIN_END: cfg_win_end = value[slc_pkg::MIN_W-1:0];
			slc_pkg::REG_INVERT: cfg_invert = value[0];
			default: ;
		endcase
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	task automatic apply_settings(input logic [slc_pkg::DELAY_W-1:0] off_delay,
			input logic [slc_pkg::DELAY_W-1:0] override_len,
			input logic [slc_pkg::DELAY_W-1:0] timeout,
			input logic win_en, input logic [slc_pkg::MIN_W-1:0] win_start,
			input logic [slc_pkg::MIN_W-1:0] win_end, input logic invert);
		quiesce();
		program_reg(slc_pkg::REG_OFF_DELAY, off_delay);
		program_reg(slc_pkg::REG_OVERRIDE, override_len);
		program_reg(slc_pkg::REG_TIMEOUT, timeout);
		program_reg(slc_pkg::REG_WIN_EN, slc_pkg::CFG_DATA_W'(win_en));
		program_reg(slc_pkg::REG_WIN_START, slc_pkg::CFG_DATA_W'(win_start));
		program_reg(slc_pkg::REG_WIN_END, slc_pkg::CFG_DATA_W'(win_end));
		program_reg(slc_pkg::REG_INVERT, slc_pkg::CFG_DATA_W'(invert));
		settings_used++;
	endtask

	task automatic run_random_traffic(input int unsigned n_items, input bit with_gaps);
		slc_pkg::slc_req_t r;
		logic lvl;
		int unsigned pick;
		int unsigned k;
		lvl = 1'b0;
		for (k = 0; k < n_items; k++) begin
			if (k % 64 == 0) gaps_on = with_gaps && ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 99);
			if ($urandom_range(0, 79) == 0) lvl = !lvl;
			r.local_motion_raw = lvl ^ ($urandom_range(0, 49) == 0);
			r.remote_source = 1'($urandom_range(0, 1));
			r.remote_active = 1'($urandom_range(0, 1));
			r.clock_valid = ($urandom_range(0, 7) != 0);
			if ($urandom_range(0, 15) == 0)
				r.minute_of_day = slc_pkg::MIN_W'($urandom_range(1440, 2047));
			else
				r.minute_of_day = slc_pkg::MIN_W'($urandom_range(0, 1439));
			if (pick < 66) r.cmd = slc_pkg::CMD_TICK;
			else if (pick < 76) r.cmd = slc_pkg::CMD_REMOTE;
			else if (pick < 86) r.cmd = slc_pkg::CMD_POLL;
			else if (pick < 89) r.cmd = slc_pkg::CMD_SHORT;
			else if (pick < 91) r.cmd = slc_pkg::CMD_LONG;
			else if (pick < 94) r.cmd = slc_pkg::CMD_FORCE_OFF;
			else if (pick < 96) r.cmd = slc_pkg::CMD_W'($urandom_range(6, 7));
			else r.cmd = slc_pkg::CMD_TICK;
			send_request(r);
		end
	endtask

	task automatic test_commands();
		send_request(make_req(3'd6, 1'b1, 1'b1, 1'b1, 11'd2047, 1'b1));
		send_request(make_req(3'd7, 1'b0, 1'b0, 1'b0, 11'd0, 1'b0));
		send_request(make_req(slc_pkg::CMD_TICK, 1'b1, 1'b0, 1'b0, 11'd0, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b0, 1'b1, 11'd1439, 1'b1));
		send_request(make_req(slc_pkg::CMD_POLL, 1'b0, 1'b0, 1'b1, 11'd1439, 1'b1));
		send_request(make_req(slc_pkg::CMD_POLL, 1'b0, 1'b1, 1'b1, 11'd720, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b1, 1'b0, 11'd720, 1'b1));
		send_request(make_req(slc_pkg::CMD_POLL, 1'b0, 1'b0, 1'b0, 11'd720, 1'b1));
		send_request(make_req(slc_pkg::CMD_POLL, 1'b0, 1'b1, 1'b0, 11'd720, 1'b1));
		send_request(make_req(slc_pkg::CMD_SHORT, 1'b0, 1'b0, 1'b0, 11'd1, 1'b1));
		send_request(make_req(slc_pkg::CMD_SHORT, 1'b0, 1'b0, 1'b0, 11'd1, 1'b1));
		send_request(make_req(slc_pkg::CMD_LONG, 1'b0, 1'b0, 1'b0, 11'd1, 1'b1));
		send_request(make_req(slc_pkg::CMD_TICK, 1'b0, 1'b0, 1'b0, 11'd2047, 1'b0));
		send_request(make_req(slc_pkg::CMD_FORCE_OFF, 1'b0, 1'b0, 1'b0, 11'd1440, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b1, 1'b1, 11'd1024, 1'b1));
	endtask

	task automatic test_time_window();
		apply_settings(31'd60000, 31'd0, 31'd0, 1'b1, 11'd600, 11'd700, 1'b0);
		send_request(make_req(slc_pkg::CMD_FORCE_OFF, 1'b0, 1'b0, 1'b0, 11'd650, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b0, 1'b1, 11'd599, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b0, 1'b1, 11'd700, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b0, 1'b1, 11'd2040, 1'b0));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b0, 1'b0, 11'd650, 1'b1));
		send_request(make_req(slc_pkg::CMD_REMOTE, 1'b0, 1'b1, 1'b1, 11'd600, 1'b1));
	endtask

	task automatic test_extreme_settings();
		apply_settings(31'd0, 31'd0, 31'h7FFF_FFFF, 1'b0, 11'd0, 11'd0, 1'b1);
		run_random_traffic(250, 1'b1);
		apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0, 1'b1, 11'd1439, 11'd0, 1'b0);
		run_random_traffic(250, 1'b1);
	endtask

	task automatic test_random_settings();
		int p;
		logic [slc_pkg::MIN_W-1:0] ws, we;
		for (p = 0; p < 3; p++) begin
			ws = slc_pkg::MIN_W'($urandom_range(0, 1439));
			we = ($urandom_range(0, 4) == 0) ? ws :
				slc_pkg::MIN_W'((ws + $urandom_range(1, 1439)) % 1440);
			apply_settings(slc_pkg::DELAY_W'($urandom_range(0, 80)),
				slc_pkg::DELAY_W'($urandom_range(0, 150)),
				($urandom_range(0, 2) == 0) ? '0 : slc_pkg::DELAY_W'($urandom_range(1, 200)),
				1'($urandom_range(0, 1)), ws, we, 1'($urandom_range(0, 1)));
			run_random_traffic(250, 1'b1);
		end
	endtask

	task automatic test_steady_flow();
		apply_settings(31'd20, 31'd60, 31'd90, 1'b1, 11'd1300, 11'd500, 1'b0);
		gaps_on = 1'b0;
		run_random_traffic(250, 1'b0);
	endtask

	initial begin
		reset_model();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_commands();
		test_time_window();
		test_extreme_settings();
		test_random_settings();
		test_steady_flow();
		quiesce();
		$display("covered %0d requests and %0d results over %0d register settings",
			requests_sent, results_seen, settings_used);
		$display("all commands, time windows, timeouts and delay extremes exercised");
		if (errors == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
